@@ src/segment_intersection_2d_macros.svh @@
// assertion macros for the segment intersection block
`ifndef SEGMENT_INTERSECTION_2D_MACROS_SVH
`define SEGMENT_INTERSECTION_2D_MACROS_SVH

// same-cycle implication
`define SEGIX_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEGIX_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/segix_pkg.sv @@
// types, widths and divider step for the segment intersection pipeline
`default_nettype none
package segix_pkg;

  localparam int W_C    = 16;
  localparam int W_D    = W_C + 1;
  localparam int W_P    = 2 * W_D;
  localparam int W_DEN  = W_P + 1;
  localparam int W_ABS  = W_P;
  localparam int W_Q    = 17;
  localparam int W_MUL  = W_ABS + W_D;
  localparam int W_NUM  = W_MUL + 1;
  localparam int N_LANE = 4;
  localparam int N_DIV  = W_Q;

  typedef enum logic [1:0] {
    REL_DISJOINT = 2'd0,
    REL_TOUCH    = 2'd1,
    REL_CROSS    = 2'd2
  } relation_t;

  typedef struct packed {
    logic rej;
    logic shr;
    logic ib0;
    logic ib1;
    logic ia0;
    logic ia1;
  } geo_flags_t;

  // lanes: frac_a, frac_b, cross_x offset, cross_y offset
  typedef struct packed {
    logic [N_LANE-1:0][W_NUM-1:0] rem;
    logic [N_LANE-1:0][W_Q-1:0]   quo;
    logic [W_DEN-1:0]             dv;
    relation_t                    rel;
    logic                         pv;
    logic                         neg_x;
    logic                         neg_y;
    logic signed [W_C-1:0]        ax0;
    logic signed [W_C-1:0]        ay0;
  } div_t;

  function automatic div_t div_step(div_t s, int unsigned b);
    div_t o;
    logic [W_NUM-1:0] sh;
    o  = s;
    sh = W_NUM'(s.dv) << b;
    for (int l = 0; l < N_LANE; l++) begin
      if (s.rem[l] >= sh) begin
        o.rem[l] = s.rem[l] - sh;
        o.quo[l] = s.quo[l] | (W_Q'(1) << b);
      end
    end
    return o;
  endfunction

endpackage
`default_nettype wire

@@ src/segment_intersection_2d.sv @@
// exact 2d segment intersection test with clamped parameters and crossing point
//
// input channel: in_valid / in_ready carry one word, the eight signed 16-bit
// endpoint coordinates of segments a and b
// output channel: out_valid / out_ready carry one word: relation, position_valid,
// cross_x, cross_y, frac_a, frac_b
// throughput: one word per cycle; seven arithmetic stages (products,
// determinants, clamping, scaling) feed a 17-stage restoring divider that
// retires one quotient bit per stage on four lanes sharing one divisor
// a stall on the output freezes the whole pipeline in place; in_ready drops
// in the same cycle, so no word is dropped or repeated
// reset clears every stage valid bit and the output valid; data is not cleared
`default_nettype none
`include "segment_intersection_2d_macros.svh"
module segment_intersection_2d (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [15:0]  a_start_x,
  input  wire logic signed [15:0]  a_start_y,
  input  wire logic signed [15:0]  a_end_x,
  input  wire logic signed [15:0]  a_end_y,
  input  wire logic signed [15:0]  b_start_x,
  input  wire logic signed [15:0]  b_start_y,
  input  wire logic signed [15:0]  b_end_x,
  input  wire logic signed [15:0]  b_end_y,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               relation,
  output logic                     position_valid,
  output logic signed [15:0]       cross_x,
  output logic signed [15:0]       cross_y,
  output logic [16:0]              frac_a,
  output logic [16:0]              frac_b
);

  localparam int W_C   = segix_pkg::W_C;
  localparam int W_D   = segix_pkg::W_D;
  localparam int W_P   = segix_pkg::W_P;
  localparam int W_DEN = segix_pkg::W_DEN;
  localparam int W_ABS = segix_pkg::W_ABS;
  localparam int W_MUL = segix_pkg::W_MUL;
  localparam int W_NUM = segix_pkg::W_NUM;
  localparam int W_Q   = segix_pkg::W_Q;
  localparam int N_DIV = segix_pkg::N_DIV;

  function automatic logic in_span(logic signed [W_C-1:0] p, logic signed [W_C-1:0] e0,
                                   logic signed [W_C-1:0] e1);
    return (p >= e0 || p >= e1) && (p <= e0 || p <= e1);
  endfunction

  function automatic logic above(logic signed [W_C-1:0] p0, logic signed [W_C-1:0] p1,
                                 logic signed [W_C-1:0] e0, logic signed [W_C-1:0] e1);
    return p0 > e0 && p0 > e1 && p1 > e0 && p1 > e1;
  endfunction

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage 1: differences, box tests and shared-endpoint tests
  logic                   v1;
  logic signed [W_D-1:0]  dax1, day1, dbx1, dby1, ex1, ey1;
  logic signed [W_C-1:0]  ax0_1, ay0_1;
  segix_pkg::geo_flags_t  fl1, fl1_next;

  always_comb begin
    fl1_next.rej = above(b_start_x, b_end_x, a_start_x, a_end_x) ||
                   above(a_start_x, a_end_x, b_start_x, b_end_x) ||
                   above(b_start_y, b_end_y, a_start_y, a_end_y) ||
                   above(a_start_y, a_end_y, b_start_y, b_end_y);
    fl1_next.shr = (a_start_x == b_start_x && a_start_y == b_start_y) ||
                   (a_start_x == b_end_x   && a_start_y == b_end_y)   ||
                   (a_end_x   == b_start_x && a_end_y   == b_start_y) ||
                   (a_end_x   == b_end_x   && a_end_y   == b_end_y);
    fl1_next.ib0 = in_span(b_start_x, a_start_x, a_end_x) &&
                   in_span(b_start_y, a_start_y, a_end_y);
    fl1_next.ib1 = in_span(b_end_x, a_start_x, a_end_x) &&
                   in_span(b_end_y, a_start_y, a_end_y);
    fl1_next.ia0 = in_span(a_start_x, b_start_x, b_end_x) &&
                   in_span(a_start_y, b_start_y, b_end_y);
    fl1_next.ia1 = in_span(a_end_x, b_start_x, b_end_x) &&
                   in_span(a_end_y, b_start_y, b_end_y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dax1  <= W_D'(a_end_x) - W_D'(a_start_x);
      day1  <= W_D'(a_end_y) - W_D'(a_start_y);
      dbx1  <= W_D'(b_end_x) - W_D'(b_start_x);
      dby1  <= W_D'(b_end_y) - W_D'(b_start_y);
      ex1   <= W_D'(a_start_x) - W_D'(b_start_x);
      ey1   <= W_D'(a_start_y) - W_D'(b_start_y);
      ax0_1 <= a_start_x;
      ay0_1 <= a_start_y;
      fl1   <= fl1_next;
    end
  end

  // stage 2: six products
  logic                   v2;
  logic signed [W_P-1:0]  p_dd, p_yx, p_bxey, p_byex, p_axey, p_ayex;
  logic signed [W_D-1:0]  dax2, day2;
  logic signed [W_C-1:0]  ax0_2, ay0_2;
  segix_pkg::geo_flags_t  fl2;

  always_ff @(posedge clk) begin
    if (en) begin
      p_dd   <= dax1 * dby1;
      p_yx   <= day1 * dbx1;
      p_bxey <= dbx1 * ey1;
      p_byex <= dby1 * ex1;
      p_axey <= dax1 * ey1;
      p_ayex <= day1 * ex1;
      dax2   <= dax1;
      day2   <= day1;
      ax0_2  <= ax0_1;
      ay0_2  <= ay0_1;
      fl2    <= fl1;
    end
  end

  // stage 3: determinant and numerators
  logic                    v3;
  logic signed [W_DEN-1:0] den3, na3, nb3;
  logic signed [W_D-1:0]   dax3, day3;
  logic signed [W_C-1:0]   ax0_3, ay0_3;
  segix_pkg::geo_flags_t   fl3;

  always_ff @(posedge clk) begin
    if (en) begin
      den3  <= W_DEN'(p_dd) - W_DEN'(p_yx);
      na3   <= W_DEN'(p_bxey) - W_DEN'(p_byex);
      nb3   <= W_DEN'(p_axey) - W_DEN'(p_ayex);
      dax3  <= dax2;
      day3  <= day2;
      ax0_3 <= ax0_2;
      ay0_3 <= ay0_2;
      fl3   <= fl2;
    end
  end

  // stage 4: classification and sign normalization
  logic                    v4;
  segix_pkg::relation_t    rel4, rel4_next;
  logic                    cross3, touch3;
  logic [W_ABS-1:0]        dabs4;
  logic signed [W_DEN-1:0] na4, nb4;
  logic                    dnz4;
  logic signed [W_D-1:0]   dax4, day4;
  logic signed [W_C-1:0]   ax0_4, ay0_4;

  always_comb begin
    cross3 = ((nb3 < 0 && den3 < nb3) || (nb3 > 0 && den3 > nb3)) &&
             ((na3 > 0 && na3 < den3) || (na3 < 0 && na3 > den3));
    touch3 = (nb3 == 0 && fl3.ib0) || (den3 == nb3 && fl3.ib1) ||
             (na3 == 0 && fl3.ia0) || (na3 == den3 && fl3.ia1);
    priority if (fl3.rej) begin
      rel4_next = segix_pkg::REL_DISJOINT;
    end else if (fl3.shr) begin
      rel4_next = segix_pkg::REL_TOUCH;
    end else if (cross3) begin
      rel4_next = segix_pkg::REL_CROSS;
    end else if (touch3) begin
      rel4_next = segix_pkg::REL_TOUCH;
    end else begin
      rel4_next = segix_pkg::REL_DISJOINT;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rel4  <= rel4_next;
      dnz4  <= den3 != 0;
      if (den3 < 0) begin
        dabs4 <= W_ABS'(-den3);
        na4   <= -na3;
        nb4   <= -nb3;
      end else begin
        dabs4 <= W_ABS'(den3);
        na4   <= na3;
        nb4   <= nb3;
      end
      dax4  <= dax3;
      day4  <= day3;
      ax0_4 <= ax0_3;
      ay0_4 <= ay0_3;
    end
  end

  // stage 5: clamp numerators to [0, den]
  logic                   v5;
  logic [W_ABS-1:0]       na5, nb5, den5;
  logic                   pv5, negx5, negy5;
  segix_pkg::relation_t   rel5;
  logic [W_D-1:0]         mx5, my5;
  logic signed [W_C-1:0]  ax0_5, ay0_5;

  always_ff @(posedge clk) begin
    if (en) begin
      if (na4 < 0) begin
        na5 <= '0;
      end else if ($unsigned(na4) > {1'b0, dabs4}) begin
        na5 <= dabs4;
      end else begin
        na5 <= na4[W_ABS-1:0];
      end
      if (nb4 < 0) begin
        nb5 <= '0;
      end else if ($unsigned(nb4) > {1'b0, dabs4}) begin
        nb5 <= dabs4;
      end else begin
        nb5 <= nb4[W_ABS-1:0];
      end
      den5  <= dabs4;
      pv5   <= (rel4 != segix_pkg::REL_DISJOINT) && dnz4;
      rel5  <= rel4;
      negx5 <= dax4 < 0;
      negy5 <= day4 < 0;
      mx5   <= (dax4 < 0) ? $unsigned(-dax4) : $unsigned(dax4);
      my5   <= (day4 < 0) ? $unsigned(-day4) : $unsigned(day4);
      ax0_5 <= ax0_4;
      ay0_5 <= ay0_4;
    end
  end

  // stage 6: scale the a numerator by the direction of segment a
  logic                   v6;
  logic [W_MUL-1:0]       prx6, pry6;
  logic [W_ABS-1:0]       na6, nb6, den6;
  logic                   pv6, negx6, negy6;
  segix_pkg::relation_t   rel6;
  logic signed [W_C-1:0]  ax0_6, ay0_6;

  always_ff @(posedge clk) begin
    if (en) begin
      prx6  <= W_MUL'(na5) * W_MUL'(mx5);
      pry6  <= W_MUL'(na5) * W_MUL'(my5);
      na6   <= na5;
      nb6   <= nb5;
      den6  <= den5;
      pv6   <= pv5;
      negx6 <= negx5;
      negy6 <= negy5;
      rel6  <= rel5;
      ax0_6 <= ax0_5;
      ay0_6 <= ay0_5;
    end
  end

  // stage 7: dividends with rounding offset
  logic                  v7;
  segix_pkg::div_t       s7, s7_next;

  always_comb begin
    s7_next.rem[0] = W_NUM'({na6, W_Q'(0)}) + W_NUM'(den6);
    s7_next.rem[1] = W_NUM'({nb6, W_Q'(0)}) + W_NUM'(den6);
    s7_next.rem[2] = W_NUM'({prx6, 1'b0}) + W_NUM'(den6) - W_NUM'(negx6);
    s7_next.rem[3] = W_NUM'({pry6, 1'b0}) + W_NUM'(den6) - W_NUM'(negy6);
    s7_next.quo    = '0;
    s7_next.dv     = {den6, 1'b0};
    s7_next.rel    = rel6;
    s7_next.pv     = pv6;
    s7_next.neg_x  = negx6;
    s7_next.neg_y  = negy6;
    s7_next.ax0    = ax0_6;
    s7_next.ay0    = ay0_6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7 <= s7_next;
    end
  end

  // divider: one quotient bit per stage, msb first
  logic [N_DIV-1:0]  vd;
  segix_pkg::div_t   sd [N_DIV];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= segix_pkg::div_step(s7, N_DIV - 1);
    end
  end

  for (genvar k = 1; k < N_DIV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k] <= segix_pkg::div_step(sd[k-1], N_DIV - 1 - k);
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      vd        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      v6        <= v5;
      v7        <= v6;
      vd        <= {vd[N_DIV-2:0], v7};
      out_valid <= vd[N_DIV-1];
    end
  end

  // output word
  segix_pkg::div_t sl;
  assign sl = sd[N_DIV-1];

  always_ff @(posedge clk) begin
    if (en) begin
      relation <= sl.rel;
      if (sl.pv) begin
        position_valid <= 1'b1;
        frac_a  <= sl.quo[0];
        frac_b  <= sl.quo[1];
        cross_x <= sl.ax0 + (sl.neg_x ? W_C'(16'd0 - sl.quo[2][W_C-1:0])
                                      : sl.quo[2][W_C-1:0]);
        cross_y <= sl.ay0 + (sl.neg_y ? W_C'(16'd0 - sl.quo[3][W_C-1:0])
                                      : sl.quo[3][W_C-1:0]);
      end else begin
        position_valid <= 1'b0;
        frac_a  <= '0;
        frac_b  <= '0;
        cross_x <= '0;
        cross_y <= '0;
      end
    end
  end

  `SEGIX_ASSERT_NEXT(a_entry, clk, rst, in_valid && in_ready, v1, "accepted word not in stage 1")
  `SEGIX_ASSERT_IMP(a_pos_rel, clk, rst, out_valid && position_valid,
    relation != segix_pkg::REL_DISJOINT, "position given for disjoint pair")
  `SEGIX_ASSERT_IMP(a_cross_pos, clk, rst, out_valid && relation == segix_pkg::REL_CROSS,
    position_valid, "proper crossing without position")
  `SEGIX_ASSERT_IMP(a_frac_rng, clk, rst, out_valid,
    frac_a <= 17'd65536 && frac_b <= 17'd65536, "fraction above one")
  `SEGIX_ASSERT_IMP(a_zero_pos, clk, rst, out_valid && !position_valid,
    frac_a == 17'd0 && cross_x == 16'sd0, "position fields not cleared")

endmodule
`default_nettype wire

@@ tb/tb_segment_intersection_2d.sv @@
// self-checking testbench for the 2d segment intersection pipeline
module tb_segment_intersection_2d;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  } seg_pair_t;

  typedef struct packed {
    segix_pkg::relation_t rel;
    logic                 pv;
    logic signed [15:0]   cx, cy;
    logic [16:0]          fa, fb;
  } hit_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] a_start_x = '0, a_start_y = '0, a_end_x = '0, a_end_y = '0;
  logic signed [15:0] b_start_x = '0, b_start_y = '0, b_end_x = '0, b_end_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] relation;
  logic position_valid;
  logic signed [15:0] cross_x, cross_y;
  logic [16:0] frac_a, frac_b;
  logic in_ready_q = 1'b0;

  seg_pair_t pending_pairs[$];
  hit_t expected_hits[$];
  bit stimulus_done = 0;
  bit hold_off = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_sent = 0;
  int n_rel[3] = '{0, 0, 0};
  int n_pos = 0;
  longint cycle_count = 0;
  int gap_left = 0;
  int burst_left = 0;

  segment_intersection_2d uut (.*);

  always #5 clk = ~clk;

  function automatic longint fdiv(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic int sgn_orient(longint x0, longint y0, longint x1, longint y1,
                                    longint x2, longint y2);
    longint c;
    c = (x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0);
    return (c > 0) - (c < 0);
  endfunction

  function automatic bit in_box(longint px, longint py, longint x0, longint y0,
                                longint x1, longint y1);
    return px >= ((x0 < x1) ? x0 : x1) && px <= ((x0 > x1) ? x0 : x1) &&
           py >= ((y0 < y1) ? y0 : y1) && py <= ((y0 > y1) ? y0 : y1);
  endfunction

  function automatic longint lmin(longint a, longint b);
    return a < b ? a : b;
  endfunction

  function automatic longint lmax(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic hit_t intersect_pair(seg_pair_t p);
    hit_t h;
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, den, na, nb;
    int o1, o2, o3, o4;
    ax0 = p.ax0; ay0 = p.ay0; ax1 = p.ax1; ay1 = p.ay1;
    bx0 = p.bx0; by0 = p.by0; bx1 = p.bx1; by1 = p.by1;
    h = '0;
    h.rel = segix_pkg::REL_DISJOINT;
    if (lmin(bx0, bx1) > lmax(ax0, ax1) || lmin(ax0, ax1) > lmax(bx0, bx1) ||
        lmin(by0, by1) > lmax(ay0, ay1) || lmin(ay0, ay1) > lmax(by0, by1)) begin
      h.rel = segix_pkg::REL_DISJOINT;
    end else if ((ax0 == bx0 && ay0 == by0) || (ax0 == bx1 && ay0 == by1) ||
                 (ax1 == bx0 && ay1 == by0) || (ax1 == bx1 && ay1 == by1)) begin
      h.rel = segix_pkg::REL_TOUCH;
    end else begin
      o1 = sgn_orient(ax0, ay0, ax1, ay1, bx0, by0);
      o2 = sgn_orient(ax0, ay0, ax1, ay1, bx1, by1);
      o3 = sgn_orient(bx0, by0, bx1, by1, ax0, ay0);
      o4 = sgn_orient(bx0, by0, bx1, by1, ax1, ay1);
      if (o1 * o2 < 0 && o3 * o4 < 0) h.rel = segix_pkg::REL_CROSS;
      else if ((o1 == 0 && in_box(bx0, by0, ax0, ay0, ax1, ay1)) ||
               (o2 == 0 && in_box(bx1, by1, ax0, ay0, ax1, ay1)) ||
               (o3 == 0 && in_box(ax0, ay0, bx0, by0, bx1, by1)) ||
               (o4 == 0 && in_box(ax1, ay1, bx0, by0, bx1, by1)))
        h.rel = segix_pkg::REL_TOUCH;
    end
    if (h.rel != segix_pkg::REL_DISJOINT) begin
      dax = ax1 - ax0; day = ay1 - ay0; dbx = bx1 - bx0; dby = by1 - by0;
      den = dax * dby - day * dbx;
      if (den != 0) begin
        na = dbx * (ay0 - by0) - dby * (ax0 - bx0);
        nb = dax * (ay0 - by0) - day * (ax0 - bx0);
        if (den < 0) begin
          den = -den; na = -na; nb = -nb;
        end
        na = (na < 0) ? 0 : (na > den) ? den : na;
        nb = (nb < 0) ? 0 : (nb > den) ? den : nb;
        h.pv = 1'b1;
        h.fa = 17'(fdiv(na * 131072 + den, 2 * den));
        h.fb = 17'(fdiv(nb * 131072 + den, 2 * den));
        h.cx = 16'(ax0 + fdiv(2 * na * dax + den, 2 * den));
        h.cy = 16'(ay0 + fdiv(2 * na * day + den, 2 * den));
      end
    end
    return h;
  endfunction

  function automatic logic signed [15:0] rand_coord(int span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'($urandom);
    if (r == 1) return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    return 16'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic seg_pair_t rand_pair();
    seg_pair_t p;
    int span, k;
    span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(2, 200);
    p.ax0 = rand_coord(span); p.ay0 = rand_coord(span);
    p.ax1 = rand_coord(span); p.ay1 = rand_coord(span);
    p.bx0 = rand_coord(span); p.by0 = rand_coord(span);
    p.bx1 = rand_coord(span); p.by1 = rand_coord(span);
    k = $urandom_range(0, 9);
    case (k)
      0: begin
        p.bx0 = p.ax1; p.by0 = p.ay1;
      end
      1: begin
        p.bx1 = p.ax0; p.by1 = p.ay0;
      end
      2: begin
        p.bx0 = p.ax0 + (p.ax1 - p.ax0) / 2; p.by0 = p.ay0 + (p.ay1 - p.ay0) / 2;
      end
      3: begin
        p.bx0 = p.ax0 + 3; p.by0 = p.ay0; p.bx1 = p.ax1 + 3; p.by1 = p.ay1;
      end
      4: begin
        p.bx0 = p.bx1; p.by0 = p.by1;
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic add_pair(int ax0, int ay0, int ax1, int ay1,
                          int bx0, int by0, int bx1, int by1);
    seg_pair_t p;
    p.ax0 = 16'(ax0); p.ay0 = 16'(ay0); p.ax1 = 16'(ax1); p.ay1 = 16'(ay1);
    p.bx0 = 16'(bx0); p.by0 = 16'(by0); p.bx1 = 16'(bx1); p.by1 = 16'(by1);
    pending_pairs = {pending_pairs, p};
  endtask

  initial begin
    add_pair(0, 0, 10, 10, 0, 10, 10, 0);
    add_pair(0, 0, 10, 0, 0, 5, 10, 5);
    add_pair(0, 0, 10, 0, 10, 0, 20, 5);
    add_pair(0, 0, 10, 0, 5, 0, 5, 7);
    add_pair(0, 0, 10, 0, 5, 0, 20, 0);
    add_pair(0, 0, 10, 0, 2, 0, 8, 0);
    add_pair(5, 5, 5, 5, 0, 0, 10, 10);
    add_pair(5, 5, 5, 5, 5, 5, 5, 5);
    add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    add_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
    add_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767);
    add_pair(0, 0, 3, 1, 1, 0, 2, 1);
    add_pair(0, 0, 1, 3, 0, 1, 1, 2);
    add_pair(0, 0, 10, 0, 20, -5, 20, 5);
    add_pair(0, 0, 10, 10, 0, 1, 10, 11);
    add_pair(-1, -1, -1, -1, 0, 0, 0, 0);
    add_pair(0, 0, 2, 2, 1, 1, 1, 1);
    add_pair(-7, 3, 9, -4, -7, -4, 9, 3);
    for (int i = 0; i < 1500; i++) pending_pairs = {pending_pairs, rand_pair()};
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // sender: bursts and gaps, payload held until accepted
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready_q) begin
        in_valid_next();
      end else if (!in_valid) begin
        in_valid_next();
      end
    end
  end

  always @(posedge clk) in_ready_q <= in_valid && in_ready;

  task automatic in_valid_next();
    seg_pair_t p;
    if (gap_left > 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending_pairs.size() == 0) begin
      in_valid <= 1'b0;
      stimulus_done = 1;
    end else begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      p = pending_pairs.pop_front();
      expected_hits = {expected_hits, intersect_pair(p)};
      n_sent++;
      in_valid <= 1'b1;
      a_start_x <= p.ax0; a_start_y <= p.ay0; a_end_x <= p.ax1; a_end_y <= p.ay1;
      b_start_x <= p.bx0; b_start_y <= p.by0; b_end_x <= p.bx1; b_end_y <= p.by1;
    end
  endtask

  // long receiver hold-off once the pipeline has had time to fill
  initial begin
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (120) @(posedge clk);
    hold_off = 0;
  end

  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else if ((cycle_count / 200) % 3 == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  // monitor
  always @(posedge clk) begin
    hit_t want, got;
    cycle_count++;
    if (!rst && out_valid && out_ready) begin
      got.rel = segix_pkg::relation_t'(relation);
      got.pv = position_valid;
      got.cx = cross_x; got.cy = cross_y;
      got.fa = frac_a; got.fb = frac_b;
      if (expected_hits.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected word: %p", got);
      end else begin
        want = expected_hits.pop_front();
        n_checked++;
        if (want.rel <= segix_pkg::REL_CROSS) n_rel[want.rel]++;
        if (want.pv) n_pos++;
        if (got !== want) begin
          n_errors++;
          if (n_errors <= 10)
            $display("mismatch: expected rel=%0d pv=%0d x=%0d y=%0d fa=%0d fb=%0d,",
                     want.rel, want.pv, want.cx, want.cy, want.fa, want.fb,
                     " got rel=%0d pv=%0d x=%0d y=%0d fa=%0d fb=%0d",
                     got.rel, got.pv, got.cx, got.cy, got.fa, got.fb);
        end
      end
    end
  end

  initial begin
    wait (stimulus_done && !in_valid && n_checked == n_sent);
    repeat (40) @(posedge clk);
    $display("checked %0d words: %0d disjoint, %0d touching, %0d crossing, %0d with position",
             n_checked, n_rel[0], n_rel[1], n_rel[2], n_pos);
    if (n_errors == 0 && expected_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count > 200000);
    $display("timeout with %0d words outstanding", expected_hits.size());
    $display("CHECK FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+src
src/segix_pkg.sv
src/segment_intersection_2d.sv
tb/tb_segment_intersection_2d.sv
